// ===== design/tcw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and codes for the text console character writer: sequencer
// states, operation codes carried in tuser, and the control characters.
// ----------------------------------------------------------------------------
package tcw_pkg;

   // operation codes, carried in req_tuser
   localparam logic [1:0] OP_PUT   = 2'd0;
   localparam logic [1:0] OP_SET   = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;
   localparam logic [1:0] OP_READ  = 2'd3;

   // control characters handled by a put
   localparam logic [7:0] CH_BS    = 8'h08;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_VT    = 8'h0B;
   localparam logic [7:0] CH_FF    = 8'h0C;
   localparam logic [7:0] CH_CR    = 8'h0D;

   // printable range and blank character
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_LAST  = 8'h7F;
   localparam logic [7:0] CH_NUL   = 8'h00;

   // attribute after reset: light grey on black
   localparam logic [7:0] ATTR_RESET = 8'h07;

   // sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV1,
      ST_DIV2,
      ST_APPLY,
      ST_COPY,
      ST_BLANK,
      ST_CLEAR,
      ST_SET,
      ST_READ,
      ST_RDWAIT,
      ST_DONE
   } state_type;

endpackage

// ===== design/tcw_mod_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_mod_unit
// Remainder of an unsigned index by a constant divisor. Reciprocal multiply,
// then multiply back and one correcting subtract; both products registered.
// ----------------------------------------------------------------------------
module tcw_mod_unit #(
   parameter int IW      = 12,
   parameter int DIVISOR = 80
) (
   input  logic                         clock,
   input  logic [IW-1:0]                idx,
   output logic [$clog2(DIVISOR)-1:0]   rem
);

   localparam int PW    = 2 * IW;
   localparam int RECIP = (2 ** IW) / DIVISOR;
   localparam int REMW  = $clog2(DIVISOR);

   logic [PW-1:0] prod_ff, prod_in;
   logic [IW-1:0] idx1_ff;
   logic [IW-1:0] qc_ff, qc_in;
   logic [IW-1:0] idx2_ff;
   logic [IW-1:0] diff;

   // stage 1: estimated quotient, low by at most one
   assign prod_in = PW'(idx) * PW'(RECIP);

   // stage 2: quotient times divisor
   assign qc_in = prod_ff[PW-1:IW] * IW'(DIVISOR);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      idx1_ff <= idx;
      qc_ff   <= qc_in;
      idx2_ff <= idx1_ff;
   end

   // stage 3: difference is below twice the divisor, correct once
   always_comb begin
      diff = idx2_ff - qc_ff;
      if (diff >= IW'(DIVISOR)) begin
         rem = REMW'(diff - IW'(DIVISOR));
      end else begin
         rem = REMW'(diff);
      end
   end

endmodule

// ===== design/text_console_char_writer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_char_writer
// Character cell console over a COLUMNS x ROWS cell memory with a linear
// cursor: put character, set cursor, clear screen and read cell items.
// ----------------------------------------------------------------------------
// One item at a time runs through a sequencer around a single cell memory
// (one write port, one registered read port). A put that moves the cursor
// past the last row scrolls the screen in place: the copy moves every cell
// up one row, then the bottom row is blanked. Clear writes every cell once.
// The next item is taken while a result still waits on the rsp side. Cell
// contents are undefined after reset: issue a clear before reading cells.
// ----------------------------------------------------------------------------
module text_console_char_writer #(
   parameter int COLUMNS   = 80,
   parameter int ROWS      = 25,
   parameter int TAB_WIDTH = 8
) (
   input  logic        clock,
   input  logic        reset,
   // request items
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // char_code[7:0], column[14:8], row[19:15]
   input  logic [1:0]  req_tuser,   // operation[1:0]
   // result items
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // cursor_pos[10:0], cell_char[18:11],
                                    // cell_attr[26:19], scrolled[27]
   // attribute register
   input  logic        csr_tvalid,
   output logic        csr_tready,
   input  logic [7:0]  csr_tdata
);

   localparam int CELLS = COLUMNS * ROWS;
   localparam int AW    = $clog2(CELLS);
   localparam int IW    = $clog2(CELLS + COLUMNS + TAB_WIDTH);
   localparam int CW    = $clog2(COLUMNS);
   localparam int RW    = $clog2(ROWS);
   localparam int TW    = $clog2(TAB_WIDTH);

   tcw_pkg::state_type state_ff, state_in;

   logic [1:0]    op_ff, op_in;
   logic [7:0]    ch_ff, ch_in;
   logic [6:0]    col_ff, col_in;
   logic [4:0]    row_ff, row_in;
   logic [IW-1:0] cur_ff, cur_in;
   logic [AW-1:0] cnt_ff, cnt_in;
   logic          scr_ff, scr_in;
   logic [7:0]    cchar_ff, cchar_in;
   logic [7:0]    cattr_ff, cattr_in;
   logic [7:0]    attr_ff;
   logic          rsp_tvalid_ff, rsp_tvalid_in;
   logic [31:0]   rsp_tdata_ff, rsp_tdata_in;

   // cell memory and its ports
   logic [15:0]   cell_mem [CELLS];
   logic [15:0]   rd_data_ff;
   logic          mem_we;
   logic [AW-1:0] waddr;
   logic [15:0]   wdata;
   logic          rd_en;
   logic [AW-1:0] raddr;

   // cursor remainders by row length and tab width
   logic [CW-1:0] rem_c;
   logic [TW-1:0] rem_t;

   logic [CW-1:0] col_cl;
   logic [RW-1:0] row_cl;
   logic [IW-1:0] pos;
   logic [IW-1:0] put_idx;
   logic          put_we;
   logic [AW-1:0] put_addr;
   logic [15:0]   put_wdata;
   logic [IW-1:0] over;
   logic [IW-1:0] scr_col;
   logic [15:0]   blank;

   assign req_tready = (state_ff == tcw_pkg::ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign csr_tready = 1'b1;
   assign blank      = {attr_ff, tcw_pkg::CH_SPACE};

   // remainder units on the cursor
   tcw_mod_unit #(.IW(IW), .DIVISOR(COLUMNS)) u_mod_col (
      .clock (clock),
      .idx   (cur_ff),
      .rem   (rem_c)
   );

   tcw_mod_unit #(.IW(IW), .DIVISOR(TAB_WIDTH)) u_mod_tab (
      .clock (clock),
      .idx   (cur_ff),
      .rem   (rem_t)
   );

   // clamped position for set cursor and read cell
   always_comb begin
      if (9'(col_ff) > 9'(COLUMNS - 1)) begin
         col_cl = CW'(COLUMNS - 1);
      end else begin
         col_cl = CW'(col_ff);
      end
      if (8'(row_ff) > 8'(ROWS - 1)) begin
         row_cl = RW'(ROWS - 1);
      end else begin
         row_cl = RW'(row_ff);
      end
      pos = IW'(row_cl) * IW'(COLUMNS) + IW'(col_cl);
   end

   // put character: new cursor and optional cell write
   always_comb begin
      put_idx   = cur_ff;
      put_we    = 1'b0;
      put_addr  = AW'(cur_ff);
      put_wdata = {attr_ff, ch_ff};
      case (ch_ff)
         tcw_pkg::CH_BS: begin
            if (cur_ff != '0) begin
               put_idx = cur_ff - IW'(1);
            end
            put_we    = 1'b1;
            put_addr  = AW'(put_idx);
            put_wdata = {attr_ff, tcw_pkg::CH_NUL};
         end
         tcw_pkg::CH_VT, tcw_pkg::CH_FF: begin
            put_idx = cur_ff + IW'(COLUMNS);
         end
         tcw_pkg::CH_TAB: begin
            put_idx = cur_ff + IW'(TAB_WIDTH) - IW'(rem_t);
         end
         tcw_pkg::CH_LF: begin
            put_idx = cur_ff - IW'(rem_c) + IW'(COLUMNS);
         end
         tcw_pkg::CH_CR: begin
            put_idx = cur_ff - IW'(rem_c);
         end
         default: begin
            if (ch_ff >= tcw_pkg::CH_SPACE && ch_ff <= tcw_pkg::CH_LAST) begin
               put_we  = 1'b1;
               put_idx = cur_ff + IW'(1);
            end
         end
      endcase
      // column after leaving the last row, overshoot stays below two rows
      over = put_idx - IW'(CELLS);
      if (over >= IW'(COLUMNS)) begin
         scr_col = over - IW'(COLUMNS);
      end else begin
         scr_col = over;
      end
   end

   // sequencer: next state, memory ports and result fields
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      ch_in         = ch_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      cur_in        = cur_ff;
      cnt_in        = cnt_ff;
      scr_in        = scr_ff;
      cchar_in      = cchar_ff;
      cattr_in      = cattr_ff;
      rsp_tvalid_in = rsp_tvalid_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      mem_we        = 1'b0;
      waddr         = cnt_ff;
      wdata         = blank;
      rd_en         = 1'b0;
      raddr         = AW'(pos);

      // result leaves the output register
      if (rsp_tvalid_ff && rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end

      case (state_ff)
         tcw_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               op_in    = req_tuser;
               ch_in    = req_tdata[7:0];
               col_in   = req_tdata[14:8];
               row_in   = req_tdata[19:15];
               scr_in   = 1'b0;
               cchar_in = 8'h00;
               cattr_in = 8'h00;
               cnt_in   = '0;
               case (req_tuser)
                  tcw_pkg::OP_PUT:   state_in = tcw_pkg::ST_DIV1;
                  tcw_pkg::OP_SET:   state_in = tcw_pkg::ST_SET;
                  tcw_pkg::OP_CLEAR: state_in = tcw_pkg::ST_CLEAR;
                  tcw_pkg::OP_READ:  state_in = tcw_pkg::ST_READ;
                  default:           state_in = tcw_pkg::ST_IDLE;
               endcase
            end
         end
         // wait for the remainder units
         tcw_pkg::ST_DIV1: begin
            state_in = tcw_pkg::ST_DIV2;
         end
         tcw_pkg::ST_DIV2: begin
            state_in = tcw_pkg::ST_APPLY;
         end
         tcw_pkg::ST_APPLY: begin
            mem_we = put_we;
            waddr  = put_addr;
            wdata  = put_wdata;
            if (put_idx >= IW'(CELLS)) begin
               cur_in   = IW'((ROWS - 1) * COLUMNS) + scr_col;
               scr_in   = 1'b1;
               cnt_in   = '0;
               state_in = tcw_pkg::ST_COPY;
            end else begin
               cur_in   = put_idx;
               state_in = tcw_pkg::ST_DONE;
            end
         end
         // move each cell up one row: read one row below, write one behind
         tcw_pkg::ST_COPY: begin
            raddr  = cnt_ff + AW'(COLUMNS);
            rd_en  = (cnt_ff != AW'(CELLS - COLUMNS));
            mem_we = (cnt_ff != '0);
            waddr  = cnt_ff - AW'(1);
            wdata  = rd_data_ff;
            if (cnt_ff == AW'(CELLS - COLUMNS)) begin
               state_in = tcw_pkg::ST_BLANK;
            end else begin
               cnt_in = cnt_ff + AW'(1);
            end
         end
         // blank the bottom row
         tcw_pkg::ST_BLANK: begin
            mem_we = 1'b1;
            if (cnt_ff == AW'(CELLS - 1)) begin
               state_in = tcw_pkg::ST_DONE;
            end else begin
               cnt_in = cnt_ff + AW'(1);
            end
         end
         tcw_pkg::ST_CLEAR: begin
            mem_we = 1'b1;
            if (cnt_ff == AW'(CELLS - 1)) begin
               cur_in   = '0;
               state_in = tcw_pkg::ST_DONE;
            end else begin
               cnt_in = cnt_ff + AW'(1);
            end
         end
         tcw_pkg::ST_SET: begin
            cur_in   = pos;
            state_in = tcw_pkg::ST_DONE;
         end
         tcw_pkg::ST_READ: begin
            rd_en    = 1'b1;
            state_in = tcw_pkg::ST_RDWAIT;
         end
         tcw_pkg::ST_RDWAIT: begin
            cchar_in = rd_data_ff[7:0];
            cattr_in = rd_data_ff[15:8];
            state_in = tcw_pkg::ST_DONE;
         end
         // hand the result over once the output register is free
         tcw_pkg::ST_DONE: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = {4'b0000, scr_ff, cattr_ff, cchar_ff, 11'(cur_ff)};
               state_in      = tcw_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tcw_pkg::ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= tcw_pkg::ST_IDLE;
         cur_ff        <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cur_ff        <= cur_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   // item payload and result fields
   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      ch_ff        <= ch_in;
      col_ff       <= col_in;
      row_ff       <= row_in;
      cnt_ff       <= cnt_in;
      scr_ff       <= scr_in;
      cchar_ff     <= cchar_in;
      cattr_ff     <= cattr_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

   // attribute register
   always_ff @(posedge clock) begin
      if (reset) begin
         attr_ff <= tcw_pkg::ATTR_RESET;
      end else if (csr_tvalid) begin
         attr_ff <= csr_tdata;
      end
   end

   // cell memory, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         cell_mem[waddr] <= wdata;
      end
      if (rd_en) begin
         rd_data_ff <= cell_mem[raddr];
      end
   end

   // no cell is touched between items
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == tcw_pkg::ST_IDLE) |-> !mem_we)
      else $error("cell write while idle");

   // the scroll copy never reads the cell it writes in the same cycle
   assert property (@(posedge clock) disable iff (reset)
      (mem_we && rd_en) |-> (waddr != raddr))
      else $error("read and write of the same cell");

   // cursor stays on screen between items
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == tcw_pkg::ST_IDLE) |-> (cur_ff < IW'(CELLS)))
      else $error("cursor off screen");

   // a scroll always leaves the cursor on the last row
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == tcw_pkg::ST_BLANK) |-> (cur_ff >= IW'((ROWS - 1) * COLUMNS)))
      else $error("scroll left cursor above last row");

endmodule

// ===== sim/tb_text_console_char_writer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_text_console_char_writer
// Self-checking bench for the text console character writer. A short
// directed table covers reset state, clamping, every control code, ignored
// bytes and scrolling. It is followed by phases of random put, set cursor,
// read and clear items, with a new attribute written between phases. Every
// result is held to its table row or a cycle-free model of screen and cursor.
// ----------------------------------------------------------------------------
module tb_text_console_char_writer;

   localparam int COLUMNS    = 80;
   localparam int ROWS       = 25;
   localparam int TAB_WIDTH  = 8;
   localparam int CELL_COUNT = COLUMNS * ROWS;
   localparam int PHASES     = 5;
   localparam int PHASE_LEN  = 140;

   typedef struct packed {
      logic [10:0] cursor_pos;
      logic [7:0]  cell_char;
      logic [7:0]  cell_attr;
      logic        scrolled;
   } console_result_type;

   typedef struct packed {
      logic [1:0]         op;
      logic [7:0]         char_code;
      logic [6:0]         column;
      logic [4:0]         row;
      logic               typed;
      console_result_type want;
   } directed_item_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic [1:0]  req_tuser = tcw_pkg::OP_PUT;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        csr_tvalid = 1'b0;
   logic        csr_tready;
   logic [7:0]  csr_tdata = '0;

   // screen and cursor as the block should hold them
   logic [15:0]        screen_model [0:CELL_COUNT-1];
   int unsigned        cursor_model;
   logic [7:0]         attr_model;
   console_result_type awaited_results [$];
   directed_item_type  directed_items [$];
   int unsigned        mismatch_count;
   bit                 sender_burst;
   bit                 receiver_burst;

   text_console_char_writer #(
      .COLUMNS   (COLUMNS),
      .ROWS      (ROWS),
      .TAB_WIDTH (TAB_WIDTH)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_tvalid (csr_tvalid),
      .csr_tready (csr_tready),
      .csr_tdata  (csr_tdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // generous cap on the whole run
   initial begin
      #100_000_000;
      $display("tb_text_console_char_writer: errors");
      $finish;
   end

   function automatic int unsigned clamp_index(logic [6:0] column, logic [4:0] row);
      int unsigned c;
      int unsigned r;
      c = (column > COLUMNS - 1) ? COLUMNS - 1 : column;
      r = (row > ROWS - 1) ? ROWS - 1 : row;
      return r * COLUMNS + c;
   endfunction

   // apply one item to the screen model and return the result it gives
   function automatic console_result_type console_apply(logic [1:0] op,
                                                        logic [7:0] char_code,
                                                        logic [6:0] column,
                                                        logic [4:0] row);
      console_result_type res;
      int unsigned        idx;
      int unsigned        i;
      logic [15:0]        cell_word;
      res = '0;
      case (op)
         tcw_pkg::OP_PUT: begin
            idx = cursor_model;
            if (char_code == tcw_pkg::CH_BS) begin
               if (idx > 0) idx--;
               screen_model[idx] = {attr_model, tcw_pkg::CH_NUL};
            end else if (char_code == tcw_pkg::CH_VT || char_code == tcw_pkg::CH_FF) begin
               idx += COLUMNS;
            end else if (char_code == tcw_pkg::CH_TAB) begin
               idx = idx + TAB_WIDTH - (idx % TAB_WIDTH);
            end else if (char_code == tcw_pkg::CH_LF) begin
               idx = idx - (idx % COLUMNS) + COLUMNS;
            end else if (char_code == tcw_pkg::CH_CR) begin
               idx -= idx % COLUMNS;
            end else if (char_code >= tcw_pkg::CH_SPACE &&
                         char_code <= tcw_pkg::CH_LAST) begin
               screen_model[idx] = {attr_model, char_code};
               idx++;
            end
            // cursor fell off the bottom: scroll up one row
            if (idx / COLUMNS >= ROWS) begin
               for (i = 0; i < CELL_COUNT - COLUMNS; i++)
                  screen_model[i] = screen_model[i + COLUMNS];
               for (i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++)
                  screen_model[i] = {attr_model, tcw_pkg::CH_SPACE};
               idx = (ROWS - 1) * COLUMNS + idx % COLUMNS;
               res.scrolled = 1'b1;
            end
            cursor_model = idx;
         end
         tcw_pkg::OP_SET: begin
            cursor_model = clamp_index(column, row);
         end
         tcw_pkg::OP_CLEAR: begin
            for (i = 0; i < CELL_COUNT; i++)
               screen_model[i] = {attr_model, tcw_pkg::CH_SPACE};
            cursor_model = 0;
         end
         default: begin
            cell_word = screen_model[clamp_index(column, row)];
            res.cell_char = cell_word[7:0];
            res.cell_attr = cell_word[15:8];
         end
      endcase
      res.cursor_pos = 11'(cursor_model);
      return res;
   endfunction

   // append one row to the directed table
   function automatic void stim_row(logic [1:0] op, logic [7:0] char_code,
                                    logic [6:0] column, logic [4:0] row,
                                    logic typed, logic [10:0] cursor_pos,
                                    logic [7:0] cell_char, logic [7:0] cell_attr,
                                    logic scrolled);
      directed_item_type item;
      item.op              = op;
      item.char_code       = char_code;
      item.column          = column;
      item.row             = row;
      item.typed           = typed;
      item.want.cursor_pos = cursor_pos;
      item.want.cell_char  = cell_char;
      item.want.cell_attr  = cell_attr;
      item.want.scrolled   = scrolled;
      directed_items.push_back(item);
   endfunction

   // present one item; valid stays high after the handshake so that a
   // back-to-back item needs no second assignment in the same step
   task automatic send_req(input logic [1:0] op, input logic [7:0] char_code,
                           input logic [6:0] column, input logic [4:0] row,
                           input logic typed, input console_result_type want);
      int unsigned        gap;
      console_result_type predicted;
      gap = sender_burst ? 0 : $urandom_range(0, 12);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {4'b0000, row, column, char_code};
      req_tuser  <= op;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predicted = console_apply(op, char_code, column, row);
      awaited_results.push_back(typed ? want : predicted);
      if ($urandom_range(0, 39) == 0) sender_burst = !sender_burst;
   endtask

   // mostly printable text and control codes, some cursor moves and reads
   task automatic send_random_item();
      int unsigned pick;
      logic [1:0]  op;
      logic [7:0]  char_code;
      logic [6:0]  column;
      logic [4:0]  row;
      pick   = $urandom_range(0, 99);
      column = 7'($urandom_range(0, 127));
      row    = 5'($urandom_range(0, 31));
      if (pick < 72)      op = tcw_pkg::OP_PUT;
      else if (pick < 84) op = tcw_pkg::OP_SET;
      else if (pick < 98) op = tcw_pkg::OP_READ;
      else                op = tcw_pkg::OP_CLEAR;
      // cursor moves lean toward the bottom rows to provoke scrolls
      if (op == tcw_pkg::OP_SET && $urandom_range(0, 1) == 1)
         row = 5'($urandom_range(22, 31));
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
         char_code = 8'($urandom_range(tcw_pkg::CH_SPACE, tcw_pkg::CH_LAST));
      end else if (pick < 80) begin
         case ($urandom_range(0, 5))
            0:       char_code = tcw_pkg::CH_BS;
            1:       char_code = tcw_pkg::CH_TAB;
            2:       char_code = tcw_pkg::CH_LF;
            3:       char_code = tcw_pkg::CH_VT;
            4:       char_code = tcw_pkg::CH_FF;
            default: char_code = tcw_pkg::CH_CR;
         endcase
      end else begin
         char_code = 8'($urandom_range(0, 255));
      end
      send_req(op, char_code, column, row, 1'b0, '0);
   endtask

   // stop sending and wait until every result is back
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (awaited_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_attribute(input logic [7:0] value);
      csr_tvalid <= 1'b1;
      csr_tdata  <= value;
      @(posedge clock);
      while (!csr_tready) @(posedge clock);
      attr_model = value;
      csr_tvalid <= 1'b0;
   endtask

   // result side: random stalls, compare each item with the oldest expectation
   initial begin
      int unsigned        stall;
      console_result_type got;
      console_result_type want;
      while (reset) @(posedge clock);
      forever begin
         stall = receiver_burst ? 0 : $urandom_range(0, 12);
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         got.cursor_pos = rsp_tdata[10:0];
         got.cell_char  = rsp_tdata[18:11];
         got.cell_attr  = rsp_tdata[26:19];
         got.scrolled   = rsp_tdata[27];
         if (awaited_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("%0t: result with nothing awaited: tdata %h", $realtime, rsp_tdata);
         end else begin
            want = awaited_results.pop_front();
            if (got.cursor_pos !== want.cursor_pos || got.cell_char !== want.cell_char ||
                got.cell_attr !== want.cell_attr || got.scrolled !== want.scrolled) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: mismatch cursor %0d/%0d char %h/%h attr %h/%h scrolled %b/%b",
                           $realtime, want.cursor_pos, got.cursor_pos, want.cell_char,
                           got.cell_char, want.cell_attr, got.cell_attr, want.scrolled,
                           got.scrolled);
            end
         end
         if ($urandom_range(0, 39) == 0) receiver_burst = !receiver_burst;
      end
   end

   // stimulus
   initial begin
      directed_item_type item;
      int unsigned       phase;
      int unsigned       n;
      cursor_model   = 0;
      attr_model     = tcw_pkg::ATTR_RESET;
      mismatch_count = 0;
      sender_burst   = 1'b0;
      receiver_burst = 1'b0;

      // clear first so that no read ever hits an unwritten cell
      stim_row(tcw_pkg::OP_CLEAR, 8'h00, 7'd0, 5'd0, 1'b1, 11'd0, 8'h00, 8'h00, 1'b0);
      stim_row(tcw_pkg::OP_READ, 8'h00, 7'd0, 5'd0, 1'b1, 11'd0, 8'h20, 8'h07, 1'b0);
      // out of range position clamps to the last cell
      stim_row(tcw_pkg::OP_READ, 8'hff, 7'd127, 5'd31, 1'b1, 11'd0, 8'h20, 8'h07, 1'b0);
      stim_row(tcw_pkg::OP_PUT, 8'h41, 7'd0, 5'd0, 1'b1, 11'd1, 8'h00, 8'h00, 1'b0);
      stim_row(tcw_pkg::OP_PUT, tcw_pkg::CH_LAST, 7'd0, 5'd0, 1'b1, 11'd2, 8'h00, 8'h00,
               1'b0);
      stim_row(tcw_pkg::OP_PUT, tcw_pkg::CH_SPACE, 7'd0, 5'd0, 1'b1, 11'd3, 8'h00, 8'h00,
               1'b0);
      // bytes outside the printable range leave everything alone
      stim_row(tcw_pkg::OP_PUT, 8'h1f, 7'd0, 5'd0, 1'b1, 11'd3, 8'h00, 8'h00, 1'b0);
      stim_row(tcw_pkg::OP_PUT, 8'h80, 7'd0, 5'd0, 1'b1, 11'd3, 8'h00, 8'h00, 1'b0);
      stim_row(tcw_pkg::OP_PUT, 8'hff, 7'd0, 5'd0, 1'b1, 11'd3, 8'h00, 8'h00, 1'b0);
      stim_row(tcw_pkg::OP_PUT, tcw_pkg::CH_TAB, 7'd0, 5'd0, 1'b1, 11'd8, 8'h00, 8'h00, 1'b0);
      stim_row(tcw_pkg::OP_PUT, tcw_pkg::CH_CR, 7'd0, 5'd0, 1'b1, 11'd0, 8'h00, 8'h00, 1'b0);
      // backspace at the home position stays there and erases cell 0
      stim_row(tcw_pkg::OP_PUT, tcw_pkg::CH_BS, 7'd0, 5'd0, 1'b1, 11'd0, 8'h00, 8'h00, 1'b0);
      stim_row(tcw_pkg::OP_READ, 8'h00, 7'd0, 5'd0, 1'b1, 11'd0, 8'h00, 8'h07, 1'b0);
      stim_row(tcw_pkg::OP_READ, 8'h00, 7'd1, 5'd0, 1'b1, 11'd0, 8'h7f, 8'h07, 1'b0);
      stim_row(tcw_pkg::OP_PUT, tcw_pkg::CH_LF, 7'd0, 5'd0, 1'b1, 11'd80, 8'h00, 8'h00, 1'b0);
      stim_row(tcw_pkg::OP_PUT, tcw_pkg::CH_VT, 7'd0, 5'd0, 1'b1, 11'd160, 8'h00, 8'h00,
               1'b0);
      stim_row(tcw_pkg::OP_PUT, tcw_pkg::CH_FF, 7'd0, 5'd0, 1'b1, 11'd240, 8'h00, 8'h00,
               1'b0);
      stim_row(tcw_pkg::OP_SET, 8'h00, 7'd127, 5'd31, 1'b1, 11'd1999, 8'h00, 8'h00, 1'b0);
      // printable at the last cell scrolls and lands on column 0 of the bottom row
      stim_row(tcw_pkg::OP_PUT, 8'h5a, 7'd0, 5'd0, 1'b1, 11'd1920, 8'h00, 8'h00, 1'b1);
      stim_row(tcw_pkg::OP_READ, 8'h00, 7'd79, 5'd23, 1'b1, 11'd1920, 8'h5a, 8'h07, 1'b0);
      stim_row(tcw_pkg::OP_READ, 8'h00, 7'd0, 5'd24, 1'b1, 11'd1920, 8'h20, 8'h07, 1'b0);
      stim_row(tcw_pkg::OP_SET, 8'h00, 7'd79, 5'd24, 1'b1, 11'd1999, 8'h00, 8'h00, 1'b0);
      // tab past the end scrolls too
      stim_row(tcw_pkg::OP_PUT, tcw_pkg::CH_TAB, 7'd0, 5'd0, 1'b1, 11'd1920, 8'h00, 8'h00,
               1'b1);
      stim_row(tcw_pkg::OP_SET, 8'h00, 7'd40, 5'd24, 1'b1, 11'd1960, 8'h00, 8'h00, 1'b0);
      // row feed from the bottom row keeps the column
      stim_row(tcw_pkg::OP_PUT, tcw_pkg::CH_VT, 7'd0, 5'd0, 1'b1, 11'd1960, 8'h00, 8'h00,
               1'b1);
      stim_row(tcw_pkg::OP_PUT, tcw_pkg::CH_BS, 7'd0, 5'd0, 1'b0, 11'd0, 8'h00, 8'h00, 1'b0);

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_items[k]) begin
         item = directed_items[k];
         send_req(item.op, item.char_code, item.column, item.row, item.typed, item.want);
      end

      // random phases, each under its own attribute
      for (phase = 0; phase < PHASES; phase++) begin
         drain_results();
         if (phase == 0)      write_attribute(8'hff);
         else if (phase == 1) write_attribute(8'h00);
         else                 write_attribute(8'($urandom_range(0, 255)));
         for (n = 0; n < PHASE_LEN; n++)
            send_random_item();
      end

      drain_results();
      repeat (2100) @(posedge clock);
      if (mismatch_count == 0 && awaited_results.size() == 0)
         $display("tb_text_console_char_writer: clean");
      else
         $display("tb_text_console_char_writer: errors");
      $finish;
   end

endmodule
